/* rtl/edu_pkg.sv */
// ----------------------------------------------------------------------------
// edu_pkg
// Shared widths, fixed-point constants and types of the equirectangular
// distance unit.
// ----------------------------------------------------------------------------
package edu_pkg;

    // input field widths and packed stream width
    localparam int LAT_W    = 28;
    localparam int LON_W    = 29;
    localparam int S_DATA_W = 120;
    localparam int DIST_W   = 32;

    // internal widths
    localparam int DLAT_W    = 28;
    localparam int DLON_W    = 29;
    localparam int X2_W      = 32;
    localparam int COS_W     = 31;
    localparam int SUM_W     = 63;
    localparam int ROOT_W    = 32;
    localparam int COS_TERMS = 7;

    // 1.0 in Q30
    localparam logic [COS_W-1:0] COS_ONE = 31'h4000_0000;

    // floor(2^32 * pi / 180)
    localparam logic [26:0] RAD_Q32 = 27'd74961320;

    // floor(2^24 * 6371 * pi / 180), km per degree
    localparam logic [30:0] KM_DEG_Q24 = 31'd1865541302;

    // coordinate differences carried alongside the cosine
    typedef struct packed {
        logic [DLAT_W-1:0] dlat;
        logic [DLON_W-1:0] dlon;
    } diff_t;

endpackage

/* rtl/edu_angle.sv */
// ----------------------------------------------------------------------------
// edu_angle
// Front end: coordinate differences, folding of the mean latitude into
// [0, 90] degrees, conversion to radians and squaring (six stages).
// ----------------------------------------------------------------------------
module edu_angle #(
    parameter int ANGLE_FRAC_BITS = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [edu_pkg::LAT_W-1:0]  first_latitude,
    input  logic signed [edu_pkg::LON_W-1:0]  first_longitude,
    input  logic signed [edu_pkg::LAT_W-1:0]  second_latitude,
    input  logic signed [edu_pkg::LON_W-1:0]  second_longitude,
    output logic                              out_valid,
    output logic [edu_pkg::X2_W-1:0]          x2,
    output edu_pkg::diff_t                    diff
);
    import edu_pkg::*;

    localparam int MEAN_W  = LAT_W + 1;
    localparam int LOW_W   = ANGLE_FRAC_BITS + 3;
    localparam int HI_W    = MEAN_W - LOW_W;
    localparam int MODP_W  = HI_W + 11;
    localparam int ANG_W   = 33;
    localparam int RPROD_W = 60;
    localparam int R_W     = 31;
    localparam logic [10:0] MOD_RECIP = 11'd1457;
    localparam logic [16:0] MOD_DIV   = 17'd45;
    localparam logic [ANG_W-1:0] HALF    = ANG_W'(180) << (ANGLE_FRAC_BITS + 1);
    localparam logic [ANG_W-1:0] QUARTER = ANG_W'(90) << (ANGLE_FRAC_BITS + 1);
    localparam logic [RPROD_W-1:0] RND_R = RPROD_W'(1) << (ANGLE_FRAC_BITS + 2);

    logic [5:0]           valid_reg;
    logic [MEAN_W-1:0]    mean_reg;
    logic [HI_W-1:0]      hi_reg;
    logic [LOW_W-1:0]     lo_reg;
    logic [MODP_W-1:0]    modp_reg;
    logic [X2_W-1:0]      ang_reg;
    logic [RPROD_W-1:0]   rprod_reg;
    logic [R_W-1:0]       r_reg;
    logic [2*R_W-1:0]     sq_reg;
    diff_t                diff_reg [0:5];

    logic signed [MEAN_W-1:0] sum_lat;
    logic signed [LAT_W:0]    d_lat;
    logic signed [LON_W:0]    d_lon;
    logic [MEAN_W-1:0]        mean_next;
    diff_t                    diff_next;
    logic [HI_W-1:0]          q_est;
    logic [16:0]              rem_raw;
    logic [16:0]              rem_fix;
    logic [ANG_W-1:0]         a_mod;
    logic [ANG_W-1:0]         a_fold;
    logic [RPROD_W-1:0]       r_sum;

    // differences and magnitude of the latitude sum
    always_comb
    begin
        sum_lat   = MEAN_W'(first_latitude) + MEAN_W'(second_latitude);
        d_lat     = (LAT_W+1)'(second_latitude) - (LAT_W+1)'(first_latitude);
        d_lon     = (LON_W+1)'(second_longitude) - (LON_W+1)'(first_longitude);
        mean_next = sum_lat[MEAN_W-1] ? MEAN_W'(-sum_lat) : MEAN_W'(sum_lat);
        diff_next.dlat = d_lat[LAT_W] ? DLAT_W'(-d_lat) : DLAT_W'(d_lat);
        diff_next.dlon = d_lon[LON_W] ? DLON_W'(-d_lon) : DLON_W'(d_lon);
    end

    // remainder modulo 180 degrees, then fold into [0, 90]
    always_comb
    begin
        q_est   = HI_W'(modp_reg >> 16);
        rem_raw = 17'(hi_reg) - 17'(q_est) * MOD_DIV;
        rem_fix = rem_raw[16] ? rem_raw + MOD_DIV : rem_raw;
        a_mod   = (ANG_W'(rem_fix[5:0]) << LOW_W) | ANG_W'(lo_reg);
        a_fold  = (a_mod > QUARTER) ? HALF - a_mod : a_mod;
    end

    // radians in Q30, rounded half up
    assign r_sum = rprod_reg + RND_R;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mean_reg    <= mean_next;
            diff_reg[0] <= diff_next;
            hi_reg      <= HI_W'(mean_reg >> LOW_W);
            lo_reg      <= mean_reg[LOW_W-1:0];
            modp_reg    <= MODP_W'(mean_reg >> LOW_W) * MODP_W'(MOD_RECIP);
            diff_reg[1] <= diff_reg[0];
            ang_reg     <= a_fold[X2_W-1:0];
            diff_reg[2] <= diff_reg[1];
            rprod_reg   <= RPROD_W'(ang_reg) * RPROD_W'(RAD_Q32);
            diff_reg[3] <= diff_reg[2];
            r_reg       <= R_W'(r_sum >> (ANGLE_FRAC_BITS + 3));
            diff_reg[4] <= diff_reg[3];
            sq_reg      <= (2*R_W)'(r_reg) * (2*R_W)'(r_reg);
            diff_reg[5] <= diff_reg[4];
        end
    end

    assign out_valid = valid_reg[5];
    assign x2        = sq_reg[X2_W+29:30];
    assign diff      = diff_reg[5];

endmodule

/* rtl/edu_cos_term.sv */
// ----------------------------------------------------------------------------
// edu_cos_term
// One Horner step of the cosine series: t = 1 - ((x2 * t) >> 30) / n,
// clamped at zero, in three stages.
// ----------------------------------------------------------------------------
module edu_cos_term #(
    parameter int TERM_K = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [edu_pkg::X2_W-1:0]    x2_in,
    input  logic [edu_pkg::COS_W-1:0]   t_in,
    input  edu_pkg::diff_t              diff_in,
    output logic                        out_valid,
    output logic [edu_pkg::X2_W-1:0]    x2_out,
    output logic [edu_pkg::COS_W-1:0]   t_out,
    output edu_pkg::diff_t              diff_out
);
    import edu_pkg::*;

    localparam int unsigned N_DIV = 2 * TERM_K * (2 * TERM_K - 1);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / N_DIV);
    localparam logic [31:0] N_VAL = 32'(N_DIV);

    logic [2:0]        valid_reg;
    logic [62:0]       prod1_reg;
    logic [31:0]       m_reg;
    logic [63:0]       prod2_reg;
    logic [COS_W-1:0]  t_reg;
    logic [X2_W-1:0]   x2_reg [0:2];
    diff_t             diff_reg [0:2];

    logic [31:0] m_next;
    logic [31:0] q0;
    logic [31:0] rem;
    logic [31:0] q;

    // product scaled back to Q30
    assign m_next = prod1_reg[61:30];

    // quotient by reciprocal, one correction step
    always_comb
    begin
        q0  = prod2_reg[63:32];
        rem = m_reg - 32'(q0 * N_VAL);
        q   = (rem >= N_VAL) ? q0 + 32'd1 : q0;
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg   <= 63'(x2_in) * 63'(t_in);
            x2_reg[0]   <= x2_in;
            diff_reg[0] <= diff_in;
            m_reg       <= m_next;
            prod2_reg   <= 64'(m_next) * 64'(RECIP);
            x2_reg[1]   <= x2_reg[0];
            diff_reg[1] <= diff_reg[0];
            t_reg       <= (q < 32'(COS_ONE)) ? COS_ONE - COS_W'(q) : '0;
            x2_reg[2]   <= x2_reg[1];
            diff_reg[2] <= diff_reg[1];
        end
    end

    assign out_valid = valid_reg[2];
    assign x2_out    = x2_reg[2];
    assign t_out     = t_reg;
    assign diff_out  = diff_reg[2];

endmodule

/* rtl/edu_sqrt.sv */
// ----------------------------------------------------------------------------
// edu_sqrt
// Pipelined digit-by-digit square root, one result bit per stage, with a
// final round-to-nearest stage.
// ----------------------------------------------------------------------------
module edu_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [edu_pkg::SUM_W-1:0]   radicand,
    output logic                        out_valid,
    output logic [edu_pkg::ROOT_W-1:0]  root
);
    import edu_pkg::*;

    localparam int RES_W = 64;

    logic [ROOT_W:0]     valid_reg;
    logic [SUM_W-1:0]    rem_reg [0:ROOT_W-1];
    logic [RES_W-1:0]    res_reg [0:ROOT_W-1];
    logic [ROOT_W-1:0]   root_reg;

    logic [SUM_W-1:0]    cur_rem [0:ROOT_W];
    logic [RES_W-1:0]    cur_res [0:ROOT_W];

    assign cur_rem[0] = radicand;
    assign cur_res[0] = '0;

    // one iteration per stage
    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stage
        localparam logic [RES_W-1:0] BIT = RES_W'(1) << (2 * (ROOT_W - 1 - i));
        logic [RES_W-1:0] trial;

        assign trial = cur_res[i] + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (RES_W'(cur_rem[i]) >= trial)
                begin
                    rem_reg[i] <= cur_rem[i] - SUM_W'(trial);
                    res_reg[i] <= (cur_res[i] >> 1) + BIT;
                end
                else
                begin
                    rem_reg[i] <= cur_rem[i];
                    res_reg[i] <= cur_res[i] >> 1;
                end
            end
        end

        assign cur_rem[i+1] = rem_reg[i];
        assign cur_res[i+1] = res_reg[i];
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[ROOT_W-1:0], in_valid};
        end
    end

    // round to nearest, ties up
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (RES_W'(cur_rem[ROOT_W]) > cur_res[ROOT_W])
            begin
                root_reg <= ROOT_W'(cur_res[ROOT_W] + RES_W'(1));
            end
            else
            begin
                root_reg <= ROOT_W'(cur_res[ROOT_W]);
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W];
    assign root      = root_reg;

endmodule

/* rtl/equirectangular_distance_unit.sv */
// ----------------------------------------------------------------------------
// equirectangular_distance_unit
// Approximate distance in km between two points given in fixed-point degrees.
// ----------------------------------------------------------------------------
// The unit takes one point pair per clock cycle while the skid register is
// empty and returns the distance in km with 16 fraction bits, saturated at
// all ones, in the order the pairs arrived. A result goes through the stages
// for differences, angle folding, radians and squaring, the seven-term
// cosine series, the scaled longitude and the sum of squares, the
// bit-per-stage square root, the km scale and the output register before it
// reaches m_axis. A skid register at the output lets the pipeline keep
// taking pairs while a result waits; stalls on m_axis freeze the pipeline
// without loss once the skid register is full.
module equirectangular_distance_unit #(
    parameter int ANGLE_FRAC_BITS = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // first_latitude, first_longitude, second_latitude, second_longitude
    input  logic [edu_pkg::S_DATA_W-1:0]    s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // distance_km
    output logic [edu_pkg::DIST_W-1:0]      m_axis_tdata
);
    import edu_pkg::*;

    localparam logic [59:0] RND_X = 60'(1) << 27;
    localparam logic [63:0] RND_D = 64'(1) << (ANGLE_FRAC_BITS + 9);

    logic en;

    logic                ang_valid;
    logic [X2_W-1:0]     ang_x2;
    diff_t               ang_diff;

    logic                cv    [0:COS_TERMS];
    logic [X2_W-1:0]     cx2   [0:COS_TERMS];
    logic [COS_W-1:0]    ct    [0:COS_TERMS];
    diff_t               cdiff [0:COS_TERMS];

    logic [3:0]          bv_reg;
    logic [59:0]         lonp_reg;
    logic [DLAT_W-1:0]   dlat_reg;
    logic [30:0]         x_reg;
    logic [29:0]         y_reg;
    logic [61:0]         xx_reg;
    logic [59:0]         yy_reg;
    logic [SUM_W-1:0]    sum_reg;

    logic                root_valid;
    logic [ROOT_W-1:0]   root;

    logic [1:0]          sv_reg;
    logic [62:0]         kmp_reg;
    logic [DIST_W-1:0]   dist_reg;

    logic                out_valid_reg;
    logic [DIST_W-1:0]   out_data_reg;
    logic                skid_valid_reg;
    logic [DIST_W-1:0]   skid_data_reg;

    logic                hand_off;
    logic [63:0]         d_sum;
    logic [63:0]         d_shift;

    // pipeline advances while the skid register is free
    assign en            = ~skid_valid_reg;
    assign s_axis_tready = en;

    // front end
    edu_angle #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_angle (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_valid         (s_axis_tvalid),
        .first_latitude   (s_axis_tdata[27:0]),
        .first_longitude  (s_axis_tdata[56:28]),
        .second_latitude  (s_axis_tdata[84:57]),
        .second_longitude (s_axis_tdata[113:85]),
        .out_valid        (ang_valid),
        .x2               (ang_x2),
        .diff             (ang_diff)
    );

    assign cv[0]    = ang_valid;
    assign cx2[0]   = ang_x2;
    assign ct[0]    = COS_ONE;
    assign cdiff[0] = ang_diff;

    // cosine series, highest term first
    for (genvar j = 0; j < COS_TERMS; j++)
    begin : g_cos
        edu_cos_term #(
            .TERM_K (COS_TERMS - j)
        ) u_term (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cv[j]),
            .x2_in     (cx2[j]),
            .t_in      (ct[j]),
            .diff_in   (cdiff[j]),
            .out_valid (cv[j+1]),
            .x2_out    (cx2[j+1]),
            .t_out     (ct[j+1]),
            .diff_out  (cdiff[j+1])
        );
    end

    // valid chain of the length stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg <= '0;
        end
        else if (en)
        begin
            bv_reg <= {bv_reg[2:0], cv[COS_TERMS]};
        end
    end

    // scaled longitude, squares and their sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lonp_reg <= 60'(cdiff[COS_TERMS].dlon) * 60'(ct[COS_TERMS]);
            dlat_reg <= cdiff[COS_TERMS].dlat;
            x_reg    <= 31'((lonp_reg + RND_X) >> 28);
            y_reg    <= {dlat_reg, 2'b00};
            xx_reg   <= 62'(x_reg) * 62'(x_reg);
            yy_reg   <= 60'(y_reg) * 60'(y_reg);
            sum_reg  <= SUM_W'(xx_reg) + SUM_W'(yy_reg);
        end
    end

    // square root
    edu_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (bv_reg[3]),
        .radicand  (sum_reg),
        .out_valid (root_valid),
        .root      (root)
    );

    // km scale, rounded half up and saturated
    always_comb
    begin
        d_sum   = 64'(kmp_reg) + RND_D;
        d_shift = d_sum >> (ANGLE_FRAC_BITS + 10);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= '0;
        end
        else if (en)
        begin
            sv_reg <= {sv_reg[0], root_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kmp_reg  <= 63'(root) * 63'(KM_DEG_Q24);
            dist_reg <= (|d_shift[63:DIST_W]) ? '1 : d_shift[DIST_W-1:0];
        end
    end

    // output register with skid stage
    assign hand_off = en & sv_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || m_axis_tready)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= hand_off;
                end
            end
            else if (hand_off)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : dist_reg;
        end
        else if (hand_off)
        begin
            skid_data_reg <= dist_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
